@@ hw/rtl/mcd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcd_pkg: shared types and constants of the motor command decoder
// beat structs, the visible state record and the command code map
// ----------------------------------------------------------------------------
package mcd_pkg;

    // pwm period loaded on run, and the base of every side compare value
    localparam logic [15:0] PWM_PERIOD   = 16'd32768;
    localparam int          SPEED_SHIFT  = 12;
    localparam int          STEP_W       = 16 - SPEED_SHIFT;

    // command byte codes
    localparam logic [7:0] CMD_STOP      = 8'd0;
    localparam logic [7:0] CMD_RUN       = 8'd1;
    localparam logic [7:0] LEFT_CENTRE   = 8'd10;
    localparam logic [7:0] LEFT_LAST     = 8'd18;
    localparam logic [7:0] RIGHT_CENTRE  = 8'd27;
    localparam logic [7:0] RIGHT_LAST    = 8'd35;
    localparam logic [7:0] TOP_CENTRE    = 8'd44;
    localparam logic [7:0] TOP_LAST      = 8'd52;
    localparam logic [7:0] SENSOR_FIRST  = 8'd53;
    localparam logic [7:0] SENSOR_LAST   = 8'd57;

    // item kinds
    localparam logic ACT_COMMAND   = 1'b0;
    localparam logic ACT_TOP_EVENT = 1'b1;

    // side compare slots
    localparam logic [1:0] SIDE_LEFT_A  = 2'd0;
    localparam logic [1:0] SIDE_LEFT_B  = 2'd1;
    localparam logic [1:0] SIDE_RIGHT_A = 2'd2;
    localparam logic [1:0] SIDE_RIGHT_B = 2'd3;

    // drive pin patterns
    localparam logic [1:0] PIN_REV  = 2'b01;
    localparam logic [1:0] PIN_FWD  = 2'b10;
    localparam logic [1:0] PIN_BOTH = 2'b11;

    typedef struct packed {
        logic       action;
        logic [7:0] command_byte;
    } t_mcd_in;

    typedef struct packed {
        logic [15:0] left_compare_a;
        logic [15:0] left_compare_b;
        logic [15:0] right_compare_a;
        logic [15:0] right_compare_b;
        logic [15:0] top_compare;
        logic        top_pwm_enable;
        logic [1:0]  top_dir_pins;
        logic        sensor_enable;
        logic [2:0]  sensor_mux;
        logic        sensor_start;
        logic        run_active;
    } t_mcd_out;

    typedef struct packed {
        logic             run_flag;
        logic [3:0][15:0] side_cmp;
        logic [15:0]      top_count;
        logic             top_enabled;
        logic             top_reversed;
        logic [1:0]       drive_pins;
        logic             sensor_power;
        logic [2:0]       mux_bits;
    } t_mcd_state;

endpackage

@@ hw/rtl/motor_command_decoder.sv @@
// ----------------------------------------------------------------------------
// motor_command_decoder: remote command and top motor pwm decoder
// keeps motor compare values, pin states and sensor mux from a beat stream
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat is either a remote command byte (action 0) or a
//   top motor pwm compare event (action 1); taken when i_in_valid is high
//   and o_in_stall is low
//   output channel: one result beat per input beat, carrying the whole
//   visible state after that beat, plus the one-beat sensor_start pulse
//   result: registered, presented in the cycle after the input beat is taken
//   throughput: one beat per cycle while the receiver does not stall; the
//   state update is a single pass of compare and subtract logic between
//   the state register and the result register
//   stall: o_in_stall rises only while a result waits and the receiver
//   stalls, so a new beat is taken in the same cycle that the pending
//   result leaves
//   reset: synchronous on i_rst_n low; all state clears to zero (stopped,
//   compares zero, pins low, sensor off) and no result is pending
// ----------------------------------------------------------------------------
module motor_command_decoder (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  mcd_pkg::t_mcd_in  i_in,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output mcd_pkg::t_mcd_out o_out
);
    import mcd_pkg::*;

    t_mcd_state r_state;
    t_mcd_state n_state;
    t_mcd_out   r_out;
    t_mcd_out   n_out;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       step_start;
    logic       in_take;

    // the result register frees up when its beat leaves this cycle
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    mcd_step u_step (
        .i_item  (i_in),
        .i_state (r_state),
        .o_state (n_state),
        .o_start (step_start)
    );

    // result beat mirrors the state after the update
    always_comb begin
        n_out.left_compare_a  = n_state.side_cmp[SIDE_LEFT_A];
        n_out.left_compare_b  = n_state.side_cmp[SIDE_LEFT_B];
        n_out.right_compare_a = n_state.side_cmp[SIDE_RIGHT_A];
        n_out.right_compare_b = n_state.side_cmp[SIDE_RIGHT_B];
        n_out.top_compare     = n_state.top_count;
        n_out.top_pwm_enable  = n_state.top_enabled;
        n_out.top_dir_pins    = n_state.drive_pins;
        n_out.sensor_enable   = n_state.sensor_power;
        n_out.sensor_mux      = n_state.mux_bits;
        n_out.sensor_start    = step_start;
        n_out.run_active      = n_state.run_flag;
    end

    // valid holds while stalled, drops once taken unless refilled
    always_comb begin
        if (in_take) begin
            n_out_valid = 1'b1;
        end else if (i_out_stall) begin
            n_out_valid = r_out_valid;
        end else begin
            n_out_valid = 1'b0;
        end
    end

    // decoder state only moves on an accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (in_take) begin
                r_state <= n_state;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTHESIS
    // mux bits are set only by the five sensor codes; stop and run only clear bit 0
    a_mux_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.mux_bits <= 3'd4)
        else $error("sensor mux out of range");

    // while stopped no side motor compare or top pwm enable can be live
    a_stopped_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.run_flag |-> (r_state.side_cmp == '0 && !r_state.top_enabled))
        else $error("motor state live while stopped");

    // every accepted beat yields a result beat next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> o_out_valid)
        else $error("accepted beat produced no result");
`endif

endmodule

@@ hw/rtl/mcd_step.sv @@
// ----------------------------------------------------------------------------
// mcd_step: next-state logic for one beat
// decodes a command byte or a top motor event against the current state
// ----------------------------------------------------------------------------
module mcd_step (
    input  mcd_pkg::t_mcd_in    i_item,
    input  mcd_pkg::t_mcd_state i_state,
    output mcd_pkg::t_mcd_state o_state,
    output logic                o_start
);
    import mcd_pkg::*;

    logic [7:0]        cmd;
    logic [7:0]        centre;
    logic              is_rev;
    logic [7:0]        diff;
    logic [STEP_W-1:0] steps;
    logic [15:0]       rev_speed;
    logic [15:0]       fwd_speed;
    logic [15:0]       cmp_a;
    logic [15:0]       cmp_b;

    assign cmd = i_item.command_byte;

    // group centre picked by code range
    always_comb begin
        if (cmd <= LEFT_LAST) begin
            centre = LEFT_CENTRE;
        end else if (cmd <= RIGHT_LAST) begin
            centre = RIGHT_CENTRE;
        end else begin
            centre = TOP_CENTRE;
        end
    end

    // distance from centre, at most eight steps inside a group
    assign is_rev    = (cmd <= centre);
    assign diff      = is_rev ? (centre - cmd) : (cmd - centre);
    assign steps     = diff[STEP_W-1:0];
    assign rev_speed = is_rev ? {steps, {SPEED_SHIFT{1'b0}}} : '0;
    assign fwd_speed = is_rev ? '0 : {steps, {SPEED_SHIFT{1'b0}}};
    assign cmp_a     = PWM_PERIOD - rev_speed;
    assign cmp_b     = PWM_PERIOD - fwd_speed;

    always_comb begin
        o_state = i_state;
        o_start = 1'b0;
        if (i_item.action == ACT_TOP_EVENT) begin
            o_state.drive_pins = i_state.drive_pins ^ (i_state.top_reversed ? PIN_REV : PIN_FWD);
            o_state.top_count  = PWM_PERIOD - i_state.top_count;
        end else if (cmd == CMD_STOP) begin
            o_state.drive_pins   = '0;
            o_state.mux_bits[0]  = 1'b0;
            o_state.sensor_power = 1'b0;
            o_state.side_cmp     = '0;
            o_state.top_enabled  = 1'b0;
            o_state.top_count    = '0;
            o_state.run_flag     = 1'b0;
        end else if (cmd == CMD_RUN) begin
            o_state.drive_pins   = PIN_BOTH;
            o_state.mux_bits[0]  = 1'b0;
            o_state.sensor_power = 1'b1;
            o_state.side_cmp     = {4{PWM_PERIOD}};
            o_state.top_enabled  = 1'b1;
            o_state.run_flag     = 1'b1;
        end else if (cmd <= LEFT_LAST) begin
            if (i_state.run_flag) begin
                o_state.side_cmp[SIDE_LEFT_A] = cmp_a;
                o_state.side_cmp[SIDE_LEFT_B] = cmp_b;
            end
        end else if (cmd <= RIGHT_LAST) begin
            if (i_state.run_flag) begin
                o_state.side_cmp[SIDE_RIGHT_A] = cmp_a;
                o_state.side_cmp[SIDE_RIGHT_B] = cmp_b;
            end
        end else if (cmd <= TOP_LAST) begin
            if (i_state.run_flag) begin
                if (steps == '0) begin
                    // centre code: brake with both pins, events off
                    o_state.drive_pins  = i_state.drive_pins | PIN_BOTH;
                    o_state.top_enabled = 1'b0;
                    o_state.top_count   = '0;
                end else begin
                    o_state.top_enabled = 1'b1;
                    o_state.top_count   = rev_speed | fwd_speed;
                    if (is_rev) begin
                        o_state.drive_pins   = PIN_REV;
                        o_state.top_reversed = 1'b1;
                    end else begin
                        o_state.drive_pins   = PIN_FWD;
                        o_state.top_reversed = 1'b0;
                    end
                end
            end
        end else if (cmd <= SENSOR_LAST) begin
            o_state.mux_bits = 3'(cmd - SENSOR_FIRST);
            o_start          = 1'b1;
        end
    end

endmodule
